// ===== rtl/arpc_pkg.sv =====
// ============================================================================
// arpc_pkg
// Shared types and constants of the IP-to-MAC address cache with aging.
// ============================================================================
package arpc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int STAMP_W = 32;
    localparam int TO_W    = 16;
    localparam int ENTRY_W = IP_W + MAC_W + STAMP_W;

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(ENTRIES - 1);
    localparam logic [TO_W-1:0]  TIMEOUT_RST = TO_W'(15);

    typedef enum logic [1:0] {
        ACT_LEARN  = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STAT_UPDATED  = 3'd0,
        STAT_INSERTED = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_HIT      = 3'd3,
        STAT_MISS     = 3'd4,
        STAT_EXPIRED  = 3'd5,
        STAT_TICK     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE
    } ctrl_state_t;

    typedef struct packed {
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wdata;
    } ram_req_t;

    typedef struct packed {
        logic             load;
        status_t          status;
        logic [MAC_W-1:0] mac;
    } result_t;

endpackage

// ===== rtl/arp_cache_with_aging.sv =====
// ============================================================================
// arp_cache_with_aging
// IP-to-MAC address cache with aging: learn, lookup and tick actions over a
// table held in a synchronous entry memory.
// ============================================================================
// A learn or lookup scans the entries through the single entry memory read
// port, in slot order up to the last slot, and then resolves into the output
// register; a hit ends the scan early. A tick or an unused action resolves
// without a scan. A result waits while the output register is not free. One
// transaction is in flight: the next one is accepted once the result loads.
// Reset clears valid bits, tick counter and the output valid bit.
// ============================================================================
module arp_cache_with_aging
    import arpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // Configuration write channel (entry timeout).
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [TO_W-1:0]  cfg_data,
    // Input channel.
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [IP_W-1:0]  ip_addr,
    input  logic [MAC_W-1:0] mac_addr,
    // Output channel.
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       status,
    output logic [MAC_W-1:0] mac_out
);

    logic [TO_W-1:0]  timeout_reg;
    logic             out_valid_reg;
    logic [2:0]       status_reg;
    logic [MAC_W-1:0] mac_out_reg;

    logic             out_free;
    ram_req_t         ram_req;
    logic [ENTRY_W-1:0] ram_rdata;
    result_t          res;

    // The user must write the timeout register only while the block is idle;
    // the block itself does not enforce it, so the port can always be ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // The output register is free when it is empty or its transaction
    // completes in this cycle; the sequencer holds its result until then.
    assign out_free = !out_valid_reg || !out_stall;

    arpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .ip_addr   (ip_addr),
        .mac_addr  (mac_addr),
        .timeout   (timeout_reg),
        .out_free  (out_free),
        .ram_rdata (entry_t'(ram_rdata)),
        .ram_req   (ram_req),
        .res       (res)
    );

    // Entry memory: address, hardware address and time stamp of each slot.
    arpc_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rdata),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            status_reg  <= res.status;
            mac_out_reg <= res.mac;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign mac_out   = mac_out_reg;

endmodule

// ===== rtl/arpc_ram.sv =====
// ============================================================================
// arpc_ram
// Simple dual-port synchronous RAM with a registered read port.
// ============================================================================
module arpc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 112,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/arpc_ctrl.sv =====
// ============================================================================
// arpc_ctrl
// Sequencer that scans the entry memory, keeps valid bits and the tick
// counter, and resolves each action into one result.
// ============================================================================
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [IP_W-1:0]  ip_addr,
    input  logic [MAC_W-1:0] mac_addr,
    input  logic [TO_W-1:0]  timeout,
    input  logic             out_free,
    input  entry_t           ram_rdata,
    output ram_req_t         ram_req,
    output result_t          res
);

    ctrl_state_t        state_reg, state_next;
    action_t            act_reg, act_next;
    logic [IP_W-1:0]    ip_reg, ip_next;
    logic [MAC_W-1:0]   mac_reg, mac_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               rd_more_reg, rd_more_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               chk_vld_reg, chk_vld_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [STAMP_W-1:0] now_reg, now_next;

    logic               match;
    logic [STAMP_W-1:0] age;

    assign match    = chk_vld_reg && valid_reg[chk_idx_reg] && (ram_rdata.ip == ip_reg);
    assign age      = now_reg - ram_rdata.stamp;
    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            now_reg        <= '0;
            rd_more_reg    <= 1'b0;
            chk_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            now_reg        <= now_next;
            rd_more_reg    <= rd_more_next;
            chk_vld_reg    <= chk_vld_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        ip_reg       <= ip_next;
        mac_reg      <= mac_next;
        rd_idx_reg   <= rd_idx_next;
        chk_idx_reg  <= chk_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        ip_next         = ip_reg;
        mac_next        = mac_reg;
        rd_idx_next     = rd_idx_reg;
        rd_more_next    = rd_more_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        now_next        = now_reg;

        ram_req         = '0;
        ram_req.rd_addr = rd_idx_reg;
        ram_req.wdata   = '{ip: ip_reg, mac: mac_reg, stamp: now_reg};
        res             = '{load: 1'b0, status: STAT_MISS, mac: '0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next        = action_t'(action);
                    ip_next         = ip_addr;
                    mac_next        = mac_addr;
                    rd_idx_next     = '0;
                    rd_more_next    = 1'b1;
                    chk_vld_next    = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    if ((action == ACT_LEARN) || (action == ACT_LOOKUP))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESOLVE;
                    end
                end
            end

            ST_SCAN:
            begin
                // Reads are pipelined one ahead of the compare; a match stops
                // further reads so the matching entry stays on the read port.
                chk_vld_next = 1'b0;
                if (rd_more_reg && !match)
                begin
                    ram_req.rd_en = 1'b1;
                    rd_idx_next   = IDX_W'(rd_idx_reg + 1'b1);
                    rd_more_next  = (rd_idx_reg != LAST_IDX);
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = rd_idx_reg;
                end
                if (chk_vld_reg)
                begin
                    if (match)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = chk_idx_reg;
                        rd_more_next = 1'b0;
                        chk_vld_next = 1'b0;
                        state_next   = ST_RESOLVE;
                    end
                    else
                    begin
                        if (!valid_reg[chk_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                        if (chk_idx_reg == LAST_IDX)
                        begin
                            state_next = ST_RESOLVE;
                        end
                    end
                end
            end

            ST_RESOLVE:
            begin
                if (out_free)
                begin
                    res.load   = 1'b1;
                    state_next = ST_IDLE;
                    unique case (act_reg)
                        ACT_LEARN:
                        begin
                            if (hit_reg)
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = hit_idx_reg;
                                res.status      = STAT_UPDATED;
                            end
                            else if (free_found_reg)
                            begin
                                ram_req.wr_en           = 1'b1;
                                ram_req.wr_addr         = free_idx_reg;
                                valid_next[free_idx_reg] = 1'b1;
                                res.status              = STAT_INSERTED;
                            end
                            else
                            begin
                                res.status = STAT_FULL;
                            end
                        end
                        ACT_LOOKUP:
                        begin
                            if (!hit_reg)
                            begin
                                res.status = STAT_MISS;
                            end
                            else if (age > STAMP_W'(timeout))
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                                res.status              = STAT_EXPIRED;
                            end
                            else
                            begin
                                res.status = STAT_HIT;
                                res.mac    = ram_rdata.mac;
                            end
                        end
                        ACT_TICK:
                        begin
                            now_next   = now_reg + 1'b1;
                            res.status = STAT_TICK;
                        end
                        ACT_NONE:
                        begin
                            res.status = STAT_MISS;
                        end
                        default:
                        begin
                            res.status = STAT_MISS;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/arpc_checker.sv =====
// ============================================================================
// arpc_checker
// Port-level checks of the address cache, bound to the top level.
// ============================================================================
module arpc_checker
    import arpc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [1:0]       action,
    input logic [IP_W-1:0]  ip_addr,
    input logic [MAC_W-1:0] mac_addr,
    input logic             out_valid,
    input logic             out_stall,
    input logic [2:0]       status,
    input logic [MAC_W-1:0] mac_out
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(mac_out))
        else $error("result changed while stalled");

    // A stalled input transaction holds its payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=>
            in_valid && $stable(action) && $stable(ip_addr) && $stable(mac_addr))
        else $error("input changed while stalled");

    // Only one transaction is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a transaction is in flight");

    // A new result appears only after the block has been busy.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a transaction in flight");

    // The hardware address is zero on every status but a hit.
    a_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_HIT) |-> (mac_out == '0))
        else $error("nonzero hardware address without a hit");

endmodule

bind arp_cache_with_aging arpc_checker u_checker (.*);

// ===== tb/arpc_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// arpc_scoreboard
// Watches the configuration, input and output channels of the address cache.
// It predicts one reply for every accepted transaction and compares each
// accepted result with the oldest reply that is still waiting.
// ============================================================================
module arpc_scoreboard
    import arpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [TO_W-1:0]  cfg_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [1:0]       action,
    input  logic [IP_W-1:0]  ip_addr,
    input  logic [MAC_W-1:0] mac_addr,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [2:0]       status,
    input  logic [MAC_W-1:0] mac_out,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        status_t          st;
        logic [MAC_W-1:0] mac;
    } cache_reply_t;

    // Shadow copy of the cache table, the tick counter and the timeout.
    logic [TO_W-1:0]    age_limit;
    logic               slot_live  [ENTRIES];
    logic [IP_W-1:0]    slot_ip    [ENTRIES];
    logic [MAC_W-1:0]   slot_mac   [ENTRIES];
    logic [STAMP_W-1:0] slot_stamp [ENTRIES];
    logic [STAMP_W-1:0] now_count;

    cache_reply_t reply_q [$];
    int           errors;

    // Lowest live slot that holds the address, or -1.
    function automatic int find_ip(input logic [IP_W-1:0] addr);
        int hit;
        hit = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (slot_live[i] && slot_ip[i] == addr)
                hit = i;
        return hit;
    endfunction

    // Lowest free slot, or -1.
    function automatic int find_free();
        int hole;
        hole = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (!slot_live[i])
                hole = i;
        return hole;
    endfunction

    task automatic apply_action(
        input  logic [1:0]       act,
        input  logic [IP_W-1:0]  addr,
        input  logic [MAC_W-1:0] hw,
        output cache_reply_t     reply
    );
        int                 s;
        logic [STAMP_W-1:0] age;
        reply.st  = STAT_MISS;
        reply.mac = '0;
        case (act)
            ACT_LEARN:
            begin
                s = find_ip(addr);
                if (s >= 0)
                begin
                    slot_mac[s]   = hw;
                    slot_stamp[s] = now_count;
                    reply.st      = STAT_UPDATED;
                end
                else
                begin
                    s = find_free();
                    if (s >= 0)
                    begin
                        slot_live[s]  = 1'b1;
                        slot_ip[s]    = addr;
                        slot_mac[s]   = hw;
                        slot_stamp[s] = now_count;
                        reply.st      = STAT_INSERTED;
                    end
                    else
                        reply.st = STAT_FULL;
                end
            end
            ACT_LOOKUP:
            begin
                s = find_ip(addr);
                if (s >= 0)
                begin
                    age = now_count - slot_stamp[s];
                    if (age > STAMP_W'(age_limit))
                    begin
                        slot_live[s] = 1'b0;
                        reply.st     = STAT_EXPIRED;
                    end
                    else
                    begin
                        reply.st  = STAT_HIT;
                        reply.mac = slot_mac[s];
                    end
                end
            end
            ACT_TICK:
            begin
                now_count = now_count + 1'b1;
                reply.st  = STAT_TICK;
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cache_reply_t oldest;
        cache_reply_t fresh;
        if (!rst_n)
        begin
            age_limit = TIMEOUT_RST;
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_live[i]  = 1'b0;
                slot_ip[i]    = '0;
                slot_mac[i]   = '0;
                slot_stamp[i] = '0;
            end
            now_count = '0;
            reply_q.delete();
            errors = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                age_limit = cfg_data;
            // A result always belongs to an earlier transaction, so it is
            // matched before this edge's input is predicted.
            if (out_valid && !out_stall)
            begin
                if (reply_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with none pending, status %0d mac_out %012h",
                                 $time, status, mac_out);
                end
                else
                begin
                    oldest = reply_q.pop_front();
                    if (status !== oldest.st || mac_out !== oldest.mac)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch, status exp %0d got %0d,",
                                      " mac_out exp %012h got %012h"},
                                     $time, oldest.st, status, oldest.mac, mac_out);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                apply_action(action, ip_addr, mac_addr, fresh);
                reply_q.push_back(fresh);
            end
            fail_count <= errors;
            pending    <= reply_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Regression of the address cache with aging. Directed learn, lookup, tick and
// expiry transactions come first, then phases of random traffic over a shared
// address pool under several timeouts, with random idling on both channels.
// ============================================================================
module tb_top;
    import arpc_pkg::*;

    localparam int POOL        = 24;     // addresses that random learns draw from
    localparam int PHASE_ITEMS = 180;    // random transactions per timeout setting
    localparam int SETTLE      = ENTRIES + 4;
    localparam int STALL_LIMIT = 2000;   // cycles without any transaction
    localparam int HOLD_CYCLES = 300;    // length of a long receiver hold-off

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [TO_W-1:0]  cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [1:0]       action    = '0;
    logic [IP_W-1:0]  ip_addr   = '0;
    logic [MAC_W-1:0] mac_addr  = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [2:0]       status;
    logic [MAC_W-1:0] mac_out;

    int               fail_count;
    int               pending;

    // Set by the stimulus during one phase so that neither side idles.
    logic             no_idle = 1'b0;

    // Random learns only ever use addresses from this pool. Lookups of pool
    // addresses later age those entries out, so no slot leaks for good.
    logic [IP_W-1:0]  ip_pool [POOL];

    arp_cache_with_aging u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .ip_addr   (ip_addr),
        .mac_addr  (mac_addr),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .mac_out   (mac_out)
    );

    arpc_scoreboard u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .ip_addr    (ip_addr),
        .mac_addr   (mac_addr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .mac_out    (mac_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom(), $urandom()});
    endfunction

    // Offers one transaction and returns at the edge where it is accepted.
    // Valid stays high into the next call unless an idle gap is inserted,
    // so back-to-back transactions never drop valid.
    task automatic send_item(
        input logic [1:0]       act,
        input logic [IP_W-1:0]  addr,
        input logic [MAC_W-1:0] hw
    );
        if (!no_idle && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        ip_addr  <= addr;
        mac_addr <= hw;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // The sender stops until every predicted result has been seen, then
    // lets the block settle before the timeout may be rewritten.
    task automatic drain_cache();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TO_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic over the first span addresses of the pool:
    // learns, lookups and ticks, with some lookups of unknown addresses and
    // some unused actions mixed in as noise.
    task automatic run_phase(input int count, input int span);
        int               r;
        logic [IP_W-1:0]  addr;
        for (int k = 0; k < count; k++)
        begin
            r    = $urandom_range(0, 99);
            addr = ip_pool[$urandom_range(0, span - 1)];
            if (r < 38)
                send_item(ACT_LEARN, addr, rand_mac());
            else if (r < 76)
                send_item(ACT_LOOKUP, addr, rand_mac());
            else if (r < 92)
                send_item(ACT_TICK, $urandom(), rand_mac());
            else if (r < 97)
                send_item(ACT_LOOKUP, $urandom(), rand_mac());
            else
                send_item(ACT_NONE, $urandom(), rand_mac());
        end
    endtask

    // Receiver: random stalls, none while no_idle is set, and two long
    // hold-offs that start while the sender is offering, so that the single
    // slot in flight stays occupied and the input channel backs up.
    initial
    begin : receiver
        int cycle_n;
        int hold_left;
        int bursts;
        int next_burst;
        cycle_n    = 0;
        hold_left  = 0;
        bursts     = 0;
        next_burst = 3000;
        forever
        begin
            @(posedge clk);
            cycle_n++;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (bursts < 2 && cycle_n >= next_burst && in_valid && !no_idle)
            begin
                out_stall  <= 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                bursts++;
                next_burst = cycle_n + 9000;
            end
            else if (no_idle)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    // Watchdog: counts the cycles in which no transaction moves on any channel and
    // ends the run once that count reaches STALL_LIMIT, a bound far beyond the slowest correct wait.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("arp_cache_with_aging regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int               phase_to [8];
        int               span;
        logic [TO_W-1:0]  limit_now;
        logic [IP_W-1:0]  fresh_ip;

        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 2; i < POOL; i++)
            ip_pool[i] = $urandom();
        phase_to = '{65535, 3, 15, 1, 0, 0, 2, 7};
        phase_to[5] = $urandom_range(16, 300);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under a timeout of one tick.
        write_timeout(TO_W'(1));
        send_item(ACT_LOOKUP, '0, '0);                   // empty table: miss
        send_item(ACT_LEARN,  '0, '0);                   // insert, zero address
        send_item(ACT_LEARN,  '1, '1);                   // insert, all-ones fields
        send_item(ACT_LOOKUP, '1, '0);                   // hit, all-ones mac
        send_item(ACT_LOOKUP, '0, '1);                   // hit, zero mac
        send_item(ACT_LEARN,  '0, 48'h5A5A_A5A5_F00F);   // update existing
        send_item(ACT_LOOKUP, '0, '0);                   // hit, new mac
        send_item(ACT_NONE,   '0, '1);                   // unused action: miss
        send_item(ACT_TICK,   '1, '1);
        send_item(ACT_LOOKUP, '0, '0);                   // age equals timeout: hit
        send_item(ACT_TICK,   '0, '0);
        send_item(ACT_LOOKUP, '0, '0);                   // age past timeout: expired
        send_item(ACT_LOOKUP, '0, '0);                   // slot freed: miss
        send_item(ACT_LEARN,  32'h1234_5678, rand_mac()); // refills lowest free slot
        send_item(ACT_LEARN,  '1, 48'h0000_0000_0001);   // refresh stamp
        send_item(ACT_LOOKUP, '1, '0);                   // hit after refresh
        send_item(ACT_TICK,   '0, '0);
        send_item(ACT_TICK,   '0, '0);
        send_item(ACT_LOOKUP, 32'h1234_5678, '0);        // expired
        send_item(ACT_NONE,   $urandom(), rand_mac());
        drain_cache();

        // Zero timeout: an entry is fresh only within the tick it was learned.
        write_timeout('0);
        fresh_ip = $urandom();
        send_item(ACT_LEARN,  fresh_ip, rand_mac());
        send_item(ACT_LOOKUP, fresh_ip, '0);             // age zero: hit
        send_item(ACT_TICK,   '0, '0);
        send_item(ACT_LOOKUP, fresh_ip, '0);             // age one: expired
        drain_cache();

        // Random phases, one timeout each. The largest timeout starts with a
        // learn of every pool address so that the table is certain to fill
        // and later learns of new addresses are dropped. One phase runs without any idling.
        for (int p = 0; p < 8; p++)
        begin
            limit_now = TO_W'(phase_to[p]);
            write_timeout(limit_now);
            no_idle = (p == 3);
            if (limit_now == '1)
            begin
                span = POOL;
                for (int k = 0; k < POOL; k++)
                    send_item(ACT_LEARN, ip_pool[k], rand_mac());
                run_phase(PHASE_ITEMS - POOL, span);
            end
            else
            begin
                span = $urandom_range(6, POOL);
                run_phase(PHASE_ITEMS, span);
            end
            drain_cache();
            no_idle = 1'b0;
        end

        if (fail_count == 0)
            $display("arp_cache_with_aging regression: pass");
        else
            $display("arp_cache_with_aging regression: fail");
        $finish;
    end

endmodule
